[design/acpu_pkg.sv]
// Shared types and constants for the accumulator CPU execute core.
// Holds opcodes, payload structs and the controller/datapath handshake structs.
// No dependencies.
package acpu_pkg;

    // Default data memory depth; the top level hands it down as a parameter.
    localparam int ACPU_DATA_DEPTH = 256;

    // Instruction codes.
    localparam logic [7:0] OP_LDM = 8'd0;
    localparam logic [7:0] OP_LDI = 8'd1;
    localparam logic [7:0] OP_STO = 8'd2;
    localparam logic [7:0] OP_ADD = 8'd3;
    localparam logic [7:0] OP_SUB = 8'd4;
    localparam logic [7:0] OP_MUL = 8'd5;
    localparam logic [7:0] OP_DIV = 8'd6;
    localparam logic [7:0] OP_INC = 8'd7;
    localparam logic [7:0] OP_DEC = 8'd8;
    localparam logic [7:0] OP_AND = 8'd9;
    localparam logic [7:0] OP_OR  = 8'd10;
    localparam logic [7:0] OP_NOT = 8'd11;
    localparam logic [7:0] OP_JMP = 8'd12;
    localparam logic [7:0] OP_JZ  = 8'd13;
    localparam logic [7:0] OP_JNZ = 8'd14;
    localparam logic [7:0] OP_JG  = 8'd15;
    localparam logic [7:0] OP_JL  = 8'd16;
    localparam logic [7:0] OP_JGE = 8'd17;
    localparam logic [7:0] OP_JLE = 8'd18;
    localparam logic [7:0] OP_HLT = 8'd19;

    // Status register bits.
    localparam logic [2:0] STAT_ZERO  = 3'b001;
    localparam logic [2:0] STAT_CARRY = 3'b010;
    localparam logic [2:0] STAT_OVF   = 3'b100;

    // One instruction on the input channel.
    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] operand;
    } instr_t;

    // One result on the output channel.
    typedef struct packed {
        logic [7:0] next_pc;
        logic [7:0] acc_value;
        logic [2:0] status_bits;
        logic       halted;
        logic       illegal;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the instruction and read data memory
        logic exec_commit;  // commit an instruction that does not use the divider
        logic div_start;    // launch the iterative divider
        logic div_commit;   // commit the quotient of a division
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_div;    // latched instruction is a division by nonzero
        logic div_done;     // divider holds a finished quotient
    } dp_status_t;

endpackage

[design/acpu_stream_if.sv]
// Valid/ready stream interface used for the instruction and result channels.
// The payload type is set per instance; no other dependencies.
interface acpu_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/acpu_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package dependencies.
module acpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/acpu_div.sv]
// Iterative 8-bit unsigned restoring divider, one quotient bit per cycle.
// Self-contained; used by the datapath for the divide instruction.
module acpu_div (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] dividend,
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);

    logic       busy_reg;
    logic       done_reg;
    logic [3:0] cnt_reg;
    logic [7:0] rem_reg;
    logic [7:0] quo_reg;
    logic [7:0] dvs_reg;

    logic [8:0] shifted;
    logic [8:0] diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[7]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd8;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 8'd0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[8])
            begin
                rem_reg <= diff[7:0];
                quo_reg <= {quo_reg[6:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[7:0];
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/acpu_datapath.sv]
// Datapath: architectural registers, data memory with valid bits, ALU and divider.
// Depends on acpu_pkg, acpu_ram and acpu_div.
module acpu_datapath
    import acpu_pkg::*;
#(
    parameter int DATA_DEPTH = ACPU_DATA_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    input  instr_t     instr_in,
    output result_t    result_out
);

    localparam int ADDR_W = $clog2(DATA_DEPTH);
    localparam int MOD_W  = 12;

    // Architectural state.
    logic [7:0] acc_reg;
    logic [7:0] pc_reg;
    logic [2:0] status_reg;
    logic       halt_reg;
    logic       illegal_reg;

    // Latched instruction.
    logic [7:0]        opcode_reg;
    logic [7:0]        operand_reg;
    logic [ADDR_W-1:0] addr_reg;

    // Data memory valid bits; an entry never written reads as zero.
    logic [DATA_DEPTH-1:0] valid_reg;
    logic                  mem_valid_reg;
    logic [7:0]            ram_rdata;

    logic [MOD_W-1:0]  mod_rem;
    logic [ADDR_W-1:0] rd_addr;

    logic [7:0]  mem_val;
    logic [7:0]  next_seq;
    logic [8:0]  sum;
    logic [15:0] prod;
    logic        div_done;
    logic [7:0]  quotient;

    logic [7:0] acc_next;
    logic [2:0] status_next;
    logic [7:0] pc_next;
    logic       halt_next;
    logic       bad;
    logic       mem_we;
    logic       set_res;
    logic [7:0] res_val;
    logic [2:0] res_flag;
    logic       take;

    // New status after a result lands in the accumulator.
    function automatic logic [2:0] status_update(
        input logic [2:0] old_status,
        input logic [7:0] value,
        input logic [2:0] flag
    );
        if (value == 8'd0)
        begin
            return STAT_ZERO | flag;
        end
        return (old_status & (STAT_CARRY | STAT_OVF)) | flag;
    endfunction

    // Address wraps modulo the memory depth: four compare-subtract steps,
    // since the quotient of an 8-bit operand by a depth of at least 16 is below 16.
    always_comb
    begin
        mod_rem = {{(MOD_W - 8){1'b0}}, instr_in.operand};
        for (int k = 3; k >= 0; k--)
        begin
            if (mod_rem >= MOD_W'(DATA_DEPTH << k))
            begin
                mod_rem = mod_rem - MOD_W'(DATA_DEPTH << k);
            end
        end
        rd_addr = mod_rem[ADDR_W-1:0];
    end

    // Data memory.
    acpu_ram #(
        .WIDTH (8),
        .DEPTH (DATA_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (addr_reg),
        .wdata (acc_reg),
        .re    (cmd.capture),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Divider.
    acpu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (mem_val),
        .done     (div_done),
        .quotient (quotient)
    );

    // Instruction latch and memory valid lookup on transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg    <= instr_in.opcode;
            operand_reg   <= instr_in.operand;
            addr_reg      <= rd_addr;
            mem_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign mem_val  = mem_valid_reg ? ram_rdata : 8'd0;
    assign next_seq = pc_reg + 8'd1;
    assign sum      = {1'b0, acc_reg} + {1'b0, mem_val};
    assign prod     = acc_reg * mem_val;

    // Instruction decode and execution of every instruction that does not use the divider.
    always_comb
    begin
        acc_next    = acc_reg;
        status_next = status_reg;
        pc_next     = pc_reg;
        halt_next   = halt_reg;
        bad         = 1'b0;
        mem_we      = 1'b0;
        set_res     = 1'b0;
        res_val     = 8'd0;
        res_flag    = 3'b000;
        take        = 1'b0;
        if (!halt_reg)
        begin
            unique case (opcode_reg) inside
                OP_LDM:
                begin
                    set_res = 1'b1;
                    res_val = mem_val;
                    pc_next = next_seq;
                end
                OP_LDI:
                begin
                    set_res = 1'b1;
                    res_val = operand_reg;
                    pc_next = next_seq;
                end
                OP_STO:
                begin
                    mem_we  = cmd.exec_commit;
                    pc_next = next_seq;
                end
                OP_ADD:
                begin
                    set_res  = 1'b1;
                    res_val  = sum[7:0];
                    res_flag = sum[8] ? STAT_CARRY : 3'b000;
                    pc_next  = next_seq;
                end
                OP_SUB:
                begin
                    set_res = 1'b1;
                    res_val = acc_reg - mem_val;
                    pc_next = next_seq;
                end
                OP_MUL:
                begin
                    set_res  = 1'b1;
                    res_val  = prod[7:0];
                    res_flag = (prod[15:8] != 8'd0) ? STAT_OVF : 3'b000;
                    pc_next  = next_seq;
                end
                OP_DIV:
                begin
                    // Division by zero keeps the accumulator and flags overflow.
                    // A real division commits later from the divider.
                    status_next = status_reg | STAT_OVF;
                    pc_next     = next_seq;
                end
                OP_INC:
                begin
                    set_res  = 1'b1;
                    res_val  = acc_reg + 8'd1;
                    res_flag = (acc_reg == 8'hFF) ? STAT_CARRY : 3'b000;
                    pc_next  = next_seq;
                end
                OP_DEC:
                begin
                    set_res = 1'b1;
                    res_val = acc_reg - 8'd1;
                    pc_next = next_seq;
                end
                OP_AND:
                begin
                    set_res = 1'b1;
                    res_val = acc_reg & mem_val;
                    pc_next = next_seq;
                end
                OP_OR:
                begin
                    set_res = 1'b1;
                    res_val = acc_reg | mem_val;
                    pc_next = next_seq;
                end
                OP_NOT:
                begin
                    set_res = 1'b1;
                    res_val = ~acc_reg;
                    pc_next = next_seq;
                end
                OP_JMP:
                begin
                    pc_next = operand_reg;
                end
                OP_JZ, OP_JLE:
                begin
                    take    = (acc_reg == 8'd0);
                    pc_next = take ? operand_reg : next_seq;
                end
                OP_JNZ, OP_JG:
                begin
                    take    = (acc_reg != 8'd0);
                    pc_next = take ? operand_reg : next_seq;
                end
                OP_JL:
                begin
                    pc_next = next_seq;
                end
                OP_JGE:
                begin
                    pc_next = operand_reg;
                end
                OP_HLT:
                begin
                    halt_next = 1'b1;
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase
        end
        if (set_res)
        begin
            acc_next    = res_val;
            status_next = status_update(status_reg, res_val, res_flag);
        end
    end

    // Architectural register update on commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= 8'd0;
            pc_reg      <= 8'd0;
            status_reg  <= 3'b000;
            halt_reg    <= 1'b0;
            illegal_reg <= 1'b0;
        end
        else if (cmd.exec_commit)
        begin
            acc_reg     <= acc_next;
            pc_reg      <= pc_next;
            status_reg  <= status_next;
            halt_reg    <= halt_next;
            illegal_reg <= bad;
        end
        else if (cmd.div_commit)
        begin
            acc_reg     <= quotient;
            pc_reg      <= next_seq;
            status_reg  <= status_update(status_reg, quotient, 3'b000);
            illegal_reg <= 1'b0;
        end
    end

    // Memory valid bits, set by every store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_we)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    assign status.needs_div = !halt_reg && (opcode_reg == OP_DIV) && (mem_val != 8'd0);
    assign status.div_done  = div_done;

    // The architectural registers only change on commit, which waits for the
    // result slot, so they serve as the result payload directly.
    assign result_out.next_pc     = pc_reg;
    assign result_out.acc_value   = acc_reg;
    assign result_out.status_bits = status_reg;
    assign result_out.halted      = halt_reg;
    assign result_out.illegal     = illegal_reg;

endmodule

[design/acpu_ctrl.sv]
// Controller state machine: sequences capture, execute and divide, and owns
// the result valid flag. Depends on acpu_pkg.
module acpu_ctrl
    import acpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       slot_free;
    logic       commit;

    // The result slot can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd.capture     = 1'b0;
        cmd.exec_commit = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.div_commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.needs_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else if (slot_free)
                begin
                    cmd.exec_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (status.div_done && slot_free)
                begin
                    cmd.div_commit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign commit = cmd.exec_commit || cmd.div_commit;

    // State and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[design/accumulator_cpu_execute_core.sv]
// Top level of the accumulator CPU execute core: controller plus datapath.
// Depends on acpu_pkg, acpu_stream_if, acpu_ctrl and acpu_datapath.
//
//   Channel  Dir  Payload                                            Transfer
//   instr    in   opcode[7:0], operand[7:0]                          valid & ready
//   result   out  next_pc, acc_value, status_bits, halted, illegal   valid & ready
//
// An instruction is captured, with its data memory read, in the idle state,
// then executes and commits in the execute state. A division by a nonzero
// value also passes through the divide state for the bit-serial divider.
// Reset is immediate: data memory reads as zero through per-entry valid bits.
// A pending result stalls the commit of the next instruction, not its transfer.
module accumulator_cpu_execute_core
    import acpu_pkg::*;
#(
    parameter int DATA_DEPTH = ACPU_DATA_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    acpu_stream_if.sink   instr,
    acpu_stream_if.source result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    instr_t     instr_payload;
    result_t    result_payload;

    assign instr_payload  = instr.payload;
    assign result.payload = result_payload;

    acpu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr.valid),
        .in_ready  (instr.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    acpu_datapath #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .instr_in   (instr_payload),
        .result_out (result_payload)
    );

    // A commit never overwrites a result that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_commit || cmd.div_commit) |-> (!result.valid || result.ready))
        else $error("commit while result slot occupied");

    // One instruction at a time: no new transfer right after one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (instr.valid && instr.ready) |=> !instr.ready)
        else $error("instruction transfer while previous still executing");

    // A quotient is committed only once the divider has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_commit |-> status.div_done)
        else $error("division committed before divider finished");

    // Every commit produces a visible result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec_commit || cmd.div_commit) |=> result.valid)
        else $error("commit did not raise result valid");

endmodule

[dv/tb_accumulator_cpu_execute_core.sv]
// Self-checking testbench for the accumulator CPU execute core.
// Depends on acpu_pkg, acpu_stream_if and the accumulator_cpu_execute_core RTL.
`timescale 1ns / 100ps

module tb_accumulator_cpu_execute_core
    import acpu_pkg::*;
();

    localparam int MEM_DEPTH = ACPU_DATA_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [7:0] OP_FIRST_ILLEGAL = OP_HLT + 8'd1;
    localparam logic [2:0] NO_FLAG = 3'b000;
    // Longest instruction (division) plus margin for the final quiet period.
    localparam int SETTLE_CYCLES = 30;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   src_valid = 1'b0;
    instr_t src_word = '0;
    logic   sink_ready = 1'b0;

    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;

    // Shadow copy of the architectural state.
    logic [7:0] acc_shadow;
    logic [7:0] pc_shadow;
    logic [2:0] status_shadow;
    logic [7:0] mem_shadow [MEM_DEPTH];
    logic       halt_shadow;

    // Results predicted for accepted instructions, oldest first.
    result_t result_queue [$];
    result_t oldest;

    acpu_stream_if #(.payload_t(instr_t))  instr_if ();
    acpu_stream_if #(.payload_t(result_t)) result_if ();

    assign instr_if.valid   = src_valid;
    assign instr_if.payload = src_word;
    assign result_if.ready  = sink_ready;

    accumulator_cpu_execute_core #(
        .DATA_DEPTH(MEM_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_if),
        .result (result_if)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side back-pressure.
    always @(posedge clk)
    begin
        sink_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic report_error(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Writes a new accumulator value and updates status from it.
    function automatic void commit_acc(input logic [7:0] value, input logic [2:0] flag);
        acc_shadow = value;
        if (value == 8'd0)
            status_shadow = STAT_ZERO | flag;
        else
            status_shadow = (status_shadow & (STAT_CARRY | STAT_OVF)) | flag;
    endfunction

    // Executes one instruction on the shadow state and returns its result.
    function automatic result_t predict_result(input logic [7:0] op, input logic [7:0] arg);
        logic [MEM_AW-1:0] idx;
        logic [7:0]  mval;
        logic [7:0]  pc_next;
        logic [8:0]  sum;
        logic [15:0] prod;
        logic        bad;
        result_t     res;
        idx     = MEM_AW'(arg % MEM_DEPTH);
        mval    = mem_shadow[idx];
        pc_next = pc_shadow + 8'd1;
        sum     = {1'b0, acc_shadow} + {1'b0, mval};
        prod    = acc_shadow * mval;
        bad     = 1'b0;
        if (!halt_shadow)
        begin
            case (op) inside
                OP_LDM: commit_acc(mval, NO_FLAG);
                OP_LDI: commit_acc(arg, NO_FLAG);
                OP_STO: mem_shadow[idx] = acc_shadow;
                OP_ADD: commit_acc(sum[7:0], sum[8] ? STAT_CARRY : NO_FLAG);
                OP_SUB: commit_acc(acc_shadow - mval, NO_FLAG);
                OP_MUL: commit_acc(prod[7:0], (prod > 16'd255) ? STAT_OVF : NO_FLAG);
                OP_DIV:
                begin
                    // Division by zero keeps the accumulator and flags overflow.
                    if (mval == 8'd0)
                        status_shadow = status_shadow | STAT_OVF;
                    else
                        commit_acc(acc_shadow / mval, NO_FLAG);
                end
                OP_INC: commit_acc(acc_shadow + 8'd1,
                                   (acc_shadow == 8'hFF) ? STAT_CARRY : NO_FLAG);
                OP_DEC: commit_acc(acc_shadow - 8'd1, NO_FLAG);
                OP_AND: commit_acc(acc_shadow & mval, NO_FLAG);
                OP_OR:  commit_acc(acc_shadow | mval, NO_FLAG);
                OP_NOT: commit_acc(~acc_shadow, NO_FLAG);
                OP_JMP: pc_shadow = arg;
                // Unsigned compares against zero.
                OP_JZ, OP_JLE: pc_shadow = (acc_shadow == 8'd0) ? arg : pc_next;
                OP_JNZ, OP_JG: pc_shadow = (acc_shadow != 8'd0) ? arg : pc_next;
                OP_JL:  pc_shadow = pc_next;
                OP_JGE: pc_shadow = arg;
                OP_HLT: halt_shadow = 1'b1;
                default: bad = 1'b1;
            endcase
            // Data instructions fall through to the next pc.
            if (!bad && op < OP_JMP)
                pc_shadow = pc_next;
        end
        res.next_pc     = pc_shadow;
        res.acc_value   = acc_shadow;
        res.status_bits = status_shadow;
        res.halted      = halt_shadow;
        res.illegal     = bad;
        return res;
    endfunction

    // Sends one instruction, with random idle cycles ahead of it.
    task automatic send_instr(input logic [7:0] op, input logic [7:0] arg);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= '{opcode: op, operand: arg};
        @(posedge clk);
        while (!instr_if.ready)
            @(posedge clk);
        result_queue.push_back(predict_result(op, arg));
    endtask

    // Holds the instruction channel idle until every result has arrived.
    task automatic drain_results();
        src_valid <= 1'b0;
        while (result_queue.size() != 0)
            @(posedge clk);
    endtask

    // Half the operands come from a few hot addresses so memory gets reused.
    function automatic logic [7:0] pick_operand();
        logic [7:0] hot;
        hot = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 0)
            return (hot < 8'd4) ? hot : (8'd248 + hot);
        return 8'($urandom_range(0, 255));
    endfunction

    // Check each result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (result_queue.size() == 0)
            begin
                report_error("result with no instruction outstanding");
            end
            else
            begin
                oldest = result_queue.pop_front();
                if (result_if.payload.next_pc !== oldest.next_pc)
                    report_error($sformatf("next_pc expected %0d, got %0d",
                                           oldest.next_pc, result_if.payload.next_pc));
                if (result_if.payload.acc_value !== oldest.acc_value)
                    report_error($sformatf("acc_value expected %0d, got %0d",
                                           oldest.acc_value, result_if.payload.acc_value));
                if (result_if.payload.status_bits !== oldest.status_bits)
                    report_error($sformatf("status_bits expected %b, got %b",
                                           oldest.status_bits, result_if.payload.status_bits));
                if (result_if.payload.halted !== oldest.halted)
                    report_error($sformatf("halted expected %b, got %b",
                                           oldest.halted, result_if.payload.halted));
                if (result_if.payload.illegal !== oldest.illegal)
                    report_error($sformatf("illegal expected %b, got %b",
                                           oldest.illegal, result_if.payload.illegal));
            end
        end
    end

    // Loads from written and never-written memory, stores at both address ends.
    task automatic test_loads_and_store();
        send_instr(OP_LDI, 8'd0);
        send_instr(OP_LDM, 8'd200);
        send_instr(OP_LDI, 8'hA5);
        send_instr(OP_STO, 8'd255);
        send_instr(OP_LDI, 8'h5A);
        send_instr(OP_STO, 8'd0);
        send_instr(OP_LDM, 8'd255);
    endtask

    // Carry on add and increment, overflow on multiply, zero clearing the sticky bits.
    task automatic test_arithmetic_flags();
        send_instr(OP_LDI, 8'd91);
        send_instr(OP_ADD, 8'd255);
        send_instr(OP_INC, 8'd0);
        send_instr(OP_SUB, 8'd255);
        send_instr(OP_LDI, 8'd255);
        send_instr(OP_INC, 8'd0);
        send_instr(OP_DEC, 8'd0);
        send_instr(OP_MUL, 8'd255);
        send_instr(OP_AND, 8'd0);
        send_instr(OP_OR, 8'd255);
        send_instr(OP_NOT, 8'd0);
    endtask

    // Division by a nonzero value, and by zero from an untouched location.
    task automatic test_divide();
        send_instr(OP_LDI, 8'd200);
        send_instr(OP_STO, 8'd7);
        send_instr(OP_DIV, 8'd7);
        send_instr(OP_DIV, 8'd100);
    endtask

    // Every conditional jump with a zero and a nonzero accumulator, then an unconditional jump.
    task automatic test_jumps();
        send_instr(OP_LDI, 8'd0);
        for (int j = OP_JZ; j <= OP_JLE; j++)
            send_instr(j[7:0], 8'd255);
        send_instr(OP_LDI, 8'd3);
        for (int j = OP_JZ; j <= OP_JLE; j++)
            send_instr(j[7:0], 8'd128);
        send_instr(OP_JMP, 8'd0);
    endtask

    task automatic test_illegal_opcodes();
        send_instr(OP_FIRST_ILLEGAL, 8'd255);
        send_instr(8'd255, 8'd0);
    endtask

    // Random instruction stream, weighted toward stores and divisions.
    task automatic run_random_program(input int count);
        logic [7:0] op;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                op = 8'($urandom_range(OP_FIRST_ILLEGAL, 255));
            else if (pick < 20)
                op = OP_STO;
            else if (pick < 32)
                op = OP_DIV;
            else
                op = 8'($urandom_range(OP_LDM, OP_JLE));
            send_instr(op, pick_operand());
        end
    endtask

    // One phase of random traffic under a given idling pattern, then a drain.
    task automatic run_phase(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        run_random_program(450);
        drain_results();
    endtask

    // Random traffic under each idling pattern, draining between them.
    task automatic test_random_phases();
        run_phase(0, 0);
        run_phase(73, 0);
        run_phase(0, 73);
        run_phase(26, 26);
    endtask

    // Halt freezes the state; later instructions only echo it.
    task automatic test_halt();
        send_instr(OP_LDI, 8'd9);
        send_instr(OP_HLT, 8'd0);
        send_instr(OP_LDI, 8'd5);
        send_instr(8'd200, 8'd1);
        send_instr(OP_HLT, 8'd0);
        send_instr(OP_JMP, 8'd4);
    endtask

    initial
    begin
        acc_shadow    = '0;
        pc_shadow     = '0;
        status_shadow = '0;
        halt_shadow   = 1'b0;
        mem_shadow    = '{default: '0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct  = 26;
        stall_pct = 26;
        test_loads_and_store();
        test_arithmetic_flags();
        test_divide();
        test_jumps();
        test_illegal_opcodes();
        drain_results();

        test_random_phases();

        idle_pct  = 26;
        stall_pct = 26;
        test_halt();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[accumulator_cpu_execute_core] OK");
        else
            $display("[accumulator_cpu_execute_core] ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("[accumulator_cpu_execute_core] ERROR");
        $finish;
    end

endmodule
